/* hw/rtl/mat_pkg.sv */
`timescale 1ns / 1ps
// mat_pkg: shared types and constants of the multi-ant turmite block
// depends on nothing; used by multi_ant_turmite_step

package mat_pkg;

  // grid and ant limits
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned MAX_ANTS   = 8;
  localparam int unsigned MAX_RULES  = 16;

  // largest grid side that the 8-bit coordinates can express
  localparam int unsigned DIM_LIM = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int unsigned HGT_LIM = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  localparam int unsigned GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CELL_AW    = $clog2(GRID_CELLS);
  localparam int unsigned CELL_W     = 4;

  // request opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_MOVED  = 2'd0;
  localparam logic [1:0] ST_PLACED = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_ANT_COUNT   = 3'd2;
  localparam logic [2:0] CFG_RULE_COUNT  = 3'd3;
  localparam logic [2:0] CFG_RULE_TURNS  = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] ant_index;
    logic [7:0] ant_x;
    logic [7:0] ant_y;
    logic [1:0] ant_direction;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] which_ant;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [3:0] cell_value;
    logic [7:0] new_x;
    logic [7:0] new_y;
    logic [1:0] new_heading;
    logic       last;
  } res_t;

endpackage

/* hw/rtl/multi_ant_turmite_step.sv */
`timescale 1ns / 1ps
// multi_ant_turmite_step: several turmites walking a toroidal 4-bit cell grid
// depends on mat_pkg and mat_ram
//
// Usage:
//   A request is taken on req_i when start_i is high and busy_o is low.
//   Results come out on result_o, each valid for exactly one cycle while
//   result_valid_o is high; the receiver must take them as they come.
//   The last result of a request has result_o.last set. A tick with zero
//   ants produces no result.
//   Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
//   cfg_data_i; ready is always high. Write only while the block is idle.
// Sequence:
//   rejected request: result in the cycle after the request
//   place / read cell: result after the grid read (S_READ, then S_DATA)
//   tick: per ant a read, an update, then two 9-step remainder passes
//   on the shared restoring remainder unit for the wrapped x and y; the
//   results come ant by ant, counting from ant 0
// Reset:
//   after rst_ni the block clears all 65536 cells of the grid memory one
//   cell per cycle, with busy_o high; config writes are still taken then.
//   Ants reset to column 0, row 0, facing up.

module multi_ant_turmite_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  mat_pkg::req_t req_i,
  output logic          result_valid_o,
  output mat_pkg::res_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  import mat_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DATA,
    S_MODX,
    S_MODY
  } state_e;

  state_e state_q;

  // configuration registers
  logic [8:0]  grid_width_q;
  logic [8:0]  grid_height_q;
  logic [3:0]  ant_count_q;
  logic [4:0]  rule_count_q;
  logic [31:0] rule_turns_q;

  // ant state
  logic [7:0] ant_col_q [MAX_ANTS];
  logic [7:0] ant_row_q [MAX_ANTS];
  logic [1:0] ant_hd_q  [MAX_ANTS];

  // request in progress
  logic [1:0]         op_q;
  logic [2:0]         idx_q;
  logic [1:0]         dir_q;
  logic [2:0]         ant_q;
  logic [7:0]         cur_x_q;
  logic [7:0]         cur_y_q;
  logic [1:0]         hd_new_q;
  logic [CELL_W-1:0]  nv_q;
  logic [7:0]         nx_q;
  logic [8:0]         num_y_q;
  logic [CELL_AW-1:0] clr_q;

  // shared remainder unit
  logic [8:0] mod_num_q;
  logic [8:0] mod_den_q;
  logic [7:0] mod_rem_q;
  logic [3:0] mod_cnt_q;
  logic [8:0] mod_trial;
  logic [7:0] mod_rem_d;

  // outputs
  logic result_valid_q;
  res_t result_q;

  // effective register values
  logic [8:0] w_eff;
  logic [8:0] h_eff;
  logic [4:0] rc_eff;
  logic [3:0] n_eff;

  // ram port
  logic               ram_we;
  logic [CELL_AW-1:0] ram_addr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_W-1:0]  ram_rdata;

  // tick step datapath
  logic [1:0]  turn;
  logic [1:0]  hd_calc;
  logic [4:0]  v_inc;
  logic [CELL_W-1:0] nv_calc;
  logic [9:0]  num_x_calc;
  logic [9:0]  num_y_calc;
  logic [2:0]  ant_nxt;
  logic        ant_last;
  logic        req_fire;
  logic        req_bad;

  // clamp odd register values
  always_comb begin
    if (grid_width_q == 9'd0) begin
      w_eff = 9'd1;
    end else if (grid_width_q > 9'(DIM_LIM)) begin
      w_eff = 9'(DIM_LIM);
    end else begin
      w_eff = grid_width_q;
    end
    if (grid_height_q == 9'd0) begin
      h_eff = 9'd1;
    end else if (grid_height_q > 9'(HGT_LIM)) begin
      h_eff = 9'(HGT_LIM);
    end else begin
      h_eff = grid_height_q;
    end
    if (rule_count_q == 5'd0) begin
      rc_eff = 5'd1;
    end else if (rule_count_q > 5'(MAX_RULES)) begin
      rc_eff = 5'(MAX_RULES);
    end else begin
      rc_eff = rule_count_q;
    end
    n_eff = (ant_count_q > 4'(MAX_ANTS)) ? 4'(MAX_ANTS) : ant_count_q;
  end

  // request decode
  assign req_fire = start_i && (state_q == S_IDLE);
  always_comb begin
    req_bad = ({1'b0, req_i.ant_x} >= w_eff) || ({1'b0, req_i.ant_y} >= h_eff);
    unique case (req_i.opcode)
      OP_TICK:  req_bad = 1'b0;
      OP_PLACE: req_bad = req_bad || ({1'b0, req_i.ant_index} >= 4'(MAX_ANTS));
      OP_READ:  req_bad = req_bad;
      default:  req_bad = 1'b1;
    endcase
  end

  // cell update, turn and wrap dividends of the current ant
  assign turn    = rule_turns_q[{ram_rdata, 1'b0} +: 2];
  assign hd_calc = ant_hd_q[ant_q] + turn;
  assign v_inc   = {1'b0, ram_rdata} + 5'd1;
  assign nv_calc = (v_inc < rc_eff) ? v_inc[CELL_W-1:0] : '0;
  always_comb begin
    num_x_calc = {2'b00, cur_x_q};
    num_y_calc = {2'b00, cur_y_q};
    unique case (hd_calc)
      2'd0:    num_y_calc = {2'b00, cur_y_q} + {1'b0, h_eff} - 10'd1;
      2'd1:    num_x_calc = {2'b00, cur_x_q} + 10'd1;
      2'd2:    num_y_calc = {2'b00, cur_y_q} + 10'd1;
      default: num_x_calc = {2'b00, cur_x_q} + {1'b0, w_eff} - 10'd1;
    endcase
  end
  assign ant_nxt  = ant_q + 3'd1;
  assign ant_last = ({1'b0, ant_q} + 4'd1) == n_eff;

  // one restoring remainder step
  assign mod_trial = {mod_rem_q, mod_num_q[8]};
  assign mod_rem_d = (mod_trial >= mod_den_q) ? 8'(mod_trial - mod_den_q)
                                              : mod_trial[7:0];

  // grid memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {cur_y_q, cur_x_q};
    ram_wdata = nv_calc;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_DATA && op_q == OP_TICK) begin
      ram_we = 1'b1;
    end
  end

  mat_ram #(
    .WIDTH (CELL_W),
    .DEPTH (GRID_CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 9'd256;
      grid_height_q <= 9'd256;
      ant_count_q   <= 4'd1;
      rule_count_q  <= 5'd2;
      rule_turns_q  <= 32'd13;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[8:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[8:0];
        CFG_ANT_COUNT:   ant_count_q   <= cfg_data_i[3:0];
        CFG_RULE_COUNT:  rule_count_q  <= cfg_data_i[4:0];
        CFG_RULE_TURNS:  rule_turns_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer, ant state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
      op_q           <= OP_TICK;
      idx_q          <= '0;
      dir_q          <= '0;
      ant_q          <= '0;
      cur_x_q        <= '0;
      cur_y_q        <= '0;
      hd_new_q       <= '0;
      nv_q           <= '0;
      nx_q           <= '0;
      num_y_q        <= '0;
      mod_num_q      <= '0;
      mod_den_q      <= '0;
      mod_rem_q      <= '0;
      mod_cnt_q      <= '0;
      for (int i = 0; i < int'(MAX_ANTS); i++) begin
        ant_col_q[i] <= '0;
        ant_row_q[i] <= '0;
        ant_hd_q[i]  <= '0;
      end
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        // sweep zeros through the grid
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end

        // take a request
        S_IDLE: begin
          if (req_fire) begin
            op_q  <= req_i.opcode;
            idx_q <= req_i.ant_index;
            dir_q <= req_i.ant_direction;
            if (req_bad) begin
              result_valid_q       <= 1'b1;
              result_q             <= '0;
              result_q.status      <= ST_REJECT;
              result_q.last        <= 1'b1;
            end else if (req_i.opcode == OP_TICK) begin
              ant_q   <= '0;
              cur_x_q <= ant_col_q[0];
              cur_y_q <= ant_row_q[0];
              if (n_eff != 4'd0) begin
                state_q <= S_READ;
              end
            end else begin
              cur_x_q <= req_i.ant_x;
              cur_y_q <= req_i.ant_y;
              state_q <= S_READ;
            end
          end
        end

        // cell address on the ram, data next cycle
        S_READ: begin
          state_q <= S_DATA;
        end

        // cell data ready
        S_DATA: begin
          if (op_q == OP_TICK) begin
            hd_new_q  <= hd_calc;
            nv_q      <= nv_calc;
            num_y_q   <= num_y_calc[8:0];
            mod_num_q <= num_x_calc[8:0];
            mod_den_q <= w_eff;
            mod_rem_q <= '0;
            mod_cnt_q <= 4'd8;
            state_q   <= S_MODX;
          end else begin
            result_valid_q       <= 1'b1;
            result_q             <= '0;
            result_q.cell_x      <= cur_x_q;
            result_q.cell_y      <= cur_y_q;
            result_q.cell_value  <= ram_rdata;
            result_q.last        <= 1'b1;
            if (op_q == OP_PLACE) begin
              result_q.status      <= ST_PLACED;
              result_q.which_ant   <= idx_q;
              result_q.new_x       <= cur_x_q;
              result_q.new_y       <= cur_y_q;
              result_q.new_heading <= dir_q;
              ant_col_q[idx_q]     <= cur_x_q;
              ant_row_q[idx_q]     <= cur_y_q;
              ant_hd_q[idx_q]      <= dir_q;
            end else begin
              result_q.status <= ST_READ;
            end
            state_q <= S_IDLE;
          end
        end

        // new column: remainder by the width
        S_MODX: begin
          mod_num_q <= {mod_num_q[7:0], 1'b0};
          mod_rem_q <= mod_rem_d;
          mod_cnt_q <= mod_cnt_q - 4'd1;
          if (mod_cnt_q == 4'd0) begin
            nx_q      <= mod_rem_d;
            mod_num_q <= num_y_q;
            mod_den_q <= h_eff;
            mod_rem_q <= '0;
            mod_cnt_q <= 4'd8;
            state_q   <= S_MODY;
          end
        end

        // new row: remainder by the height, then emit the move
        S_MODY: begin
          mod_num_q <= {mod_num_q[7:0], 1'b0};
          mod_rem_q <= mod_rem_d;
          mod_cnt_q <= mod_cnt_q - 4'd1;
          if (mod_cnt_q == 4'd0) begin
            result_valid_q       <= 1'b1;
            result_q.status      <= ST_MOVED;
            result_q.which_ant   <= ant_q;
            result_q.cell_x      <= cur_x_q;
            result_q.cell_y      <= cur_y_q;
            result_q.cell_value  <= nv_q;
            result_q.new_x       <= nx_q;
            result_q.new_y       <= mod_rem_d;
            result_q.new_heading <= hd_new_q;
            result_q.last        <= ant_last;
            ant_col_q[ant_q]     <= nx_q;
            ant_row_q[ant_q]     <= mod_rem_d;
            ant_hd_q[ant_q]      <= hd_new_q;
            if (ant_last) begin
              state_q <= S_IDLE;
            end else begin
              ant_q   <= ant_nxt;
              cur_x_q <= ant_col_q[ant_nxt];
              cur_y_q <= ant_row_q[ant_nxt];
              state_q <= S_READ;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;
  assign cfg_ready_o    = 1'b1;

endmodule

/* hw/rtl/mat_ram.sv */
`timescale 1ns / 1ps
// mat_ram: generic single-port RAM with registered read
// depends on nothing

module mat_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* bench/tb_multi_ant_turmite_step.sv */
`timescale 1ns / 1ps
// tb_multi_ant_turmite_step: self-checking bench for the multi-ant turmite block
// depends on mat_pkg and multi_ant_turmite_step; predicts every result in-line
// and compares it against the block output across several register settings

module tb_multi_ant_turmite_step;
  import mat_pkg::*;

  // opcode with no operation behind it, always rejected
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // ant headings
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  // quiet time after the last result before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned DRAIN_LIMIT   = 100000;
  localparam int unsigned RANDOM_PER_PHASE = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  req_t        req_i = '0;
  logic        result_valid_o;
  res_t        result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  multi_ant_turmite_step DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of registers, grid and ants
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [3:0]  ants_reg;
  logic [4:0]  rules_reg;
  logic [31:0] turns_reg;
  logic [3:0]  grid_model [GRID_CELLS];
  logic [7:0]  ant_x_now [MAX_ANTS];
  logic [7:0]  ant_y_now [MAX_ANTS];
  logic [1:0]  ant_dir_now [MAX_ANTS];

  req_t pending_requests [$];
  res_t expected_results [$];

  int unsigned errors;
  int unsigned results_checked;
  int unsigned ticks_sent, places_sent, reads_sent, rejects_seen;
  int unsigned settings_applied;
  int unsigned burst_left, gap_left;

  // side of the grid in use: zero acts as one, large values saturate
  function automatic int unsigned clamp_side(logic [8:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic string res_text(res_t r);
    return $sformatf("st=%0d ant=%0d cell=(%0d,%0d) val=%0d new=(%0d,%0d) hd=%0d last=%0d",
                     r.status, r.which_ant, r.cell_x, r.cell_y, r.cell_value,
                     r.new_x, r.new_y, r.new_heading, r.last);
  endfunction

  // expected results of one accepted request; updates the shadow state
  task automatic predict_outcome(input req_t r);
    int unsigned w, h, n, rc, i, cx, cy, nx, ny, addr, v, nv;
    logic [1:0] turn, hd;
    res_t res;
    w = clamp_side(width_reg, DIM_LIM);
    h = clamp_side(height_reg, HGT_LIM);
    res = '0;
    res.status = ST_REJECT;
    res.last = 1'b1;
    case (r.opcode)
      OP_TICK: begin
        ticks_sent++;
        n = (ants_reg > MAX_ANTS) ? MAX_ANTS : ants_reg;
        rc = clamp_side({4'd0, rules_reg}, MAX_RULES);
        for (i = 0; i < n; i++) begin
          cx = ant_x_now[i];
          cy = ant_y_now[i];
          addr = (cy % MAX_HEIGHT) * MAX_WIDTH + (cx % MAX_WIDTH);
          v = grid_model[addr];
          turn = turns_reg[2*v +: 2];
          hd = ant_dir_now[i] + turn;
          nv = (v + 1 < rc) ? v + 1 : 0;
          grid_model[addr] = nv[3:0];
          nx = cx % w;
          ny = cy % h;
          case (hd)
            HEAD_UP:    ny = (cy + h - 1) % h;
            HEAD_RIGHT: nx = (cx + 1) % w;
            HEAD_DOWN:  ny = (cy + 1) % h;
            HEAD_LEFT:  nx = (cx + w - 1) % w;
          endcase
          ant_x_now[i] = nx[7:0];
          ant_y_now[i] = ny[7:0];
          ant_dir_now[i] = hd;
          res.status = ST_MOVED;
          res.which_ant = i[2:0];
          res.cell_x = cx[7:0];
          res.cell_y = cy[7:0];
          res.cell_value = nv[3:0];
          res.new_x = nx[7:0];
          res.new_y = ny[7:0];
          res.new_heading = hd;
          res.last = (i + 1 == n);
          expected_results.push_back(res);
        end
      end
      OP_PLACE: begin
        places_sent++;
        if (r.ant_x < w && r.ant_y < h && r.ant_index < MAX_ANTS) begin
          ant_x_now[r.ant_index] = r.ant_x;
          ant_y_now[r.ant_index] = r.ant_y;
          ant_dir_now[r.ant_index] = r.ant_direction;
          res.status = ST_PLACED;
          res.which_ant = r.ant_index;
          res.cell_x = r.ant_x;
          res.cell_y = r.ant_y;
          res.cell_value = grid_model[{r.ant_y, r.ant_x}];
          res.new_x = r.ant_x;
          res.new_y = r.ant_y;
          res.new_heading = r.ant_direction;
        end
        expected_results.push_back(res);
      end
      OP_READ: begin
        reads_sent++;
        if (r.ant_x < w && r.ant_y < h) begin
          res.status = ST_READ;
          res.cell_x = r.ant_x;
          res.cell_y = r.ant_y;
          res.cell_value = grid_model[{r.ant_y, r.ant_x}];
        end
        expected_results.push_back(res);
      end
      default: expected_results.push_back(res);
    endcase
    if (r.opcode != OP_TICK && res.status == ST_REJECT) rejects_seen++;
  endtask

  // request driver: bursts of requests with random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (start_i && !busy_o) predict_outcome(req_i);
      if (start_i && busy_o) begin
        // hold the request until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        req_i <= pending_requests.pop_front();
        start_i <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            5:       gap_left = $urandom_range(20, 40);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // result monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result at %0t: %s", $realtime, res_text(result_o));
      end else begin
        if (result_o !== expected_results[0]) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", res_text(expected_results[0]));
            $display("  got      %s", res_text(result_o));
          end
        end
        void'(expected_results.pop_front());
        results_checked++;
      end
    end
  end

  task automatic queue_request(input logic [1:0] op, input logic [2:0] idx,
                               input logic [7:0] x, input logic [7:0] y,
                               input logic [1:0] dir);
    req_t r;
    r.opcode = op;
    r.ant_index = idx;
    r.ant_x = x;
    r.ant_y = y;
    r.ant_direction = dir;
    pending_requests.push_back(r);
  endtask

  // mostly ticks and on-grid places and reads, some off-grid and unused opcodes
  task automatic queue_random(input int unsigned count);
    int unsigned w, h, pick, k;
    req_t r;
    w = clamp_side(width_reg, DIM_LIM);
    h = clamp_side(height_reg, HGT_LIM);
    for (k = 0; k < count; k++) begin
      r.ant_index = 3'($urandom_range(0, 7));
      r.ant_direction = 2'($urandom_range(0, 3));
      r.ant_x = 8'($urandom_range(0, w - 1));
      r.ant_y = 8'($urandom_range(0, h - 1));
      pick = $urandom_range(0, 99);
      if (pick < 50) r.opcode = OP_TICK;
      else if (pick < 72) r.opcode = OP_PLACE;
      else if (pick < 94) r.opcode = OP_READ;
      else r.opcode = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) begin
        r.ant_x = 8'($urandom_range(0, 255));
        r.ant_y = 8'($urandom_range(0, 255));
      end
      pending_requests.push_back(r);
    end
  endtask

  // wait until all requests are taken, all results are in and the block is idle
  task automatic await_idle();
    int unsigned waited;
    waited = 0;
    do begin
      @(negedge clk_i);
      waited++;
    end while ((pending_requests.size() != 0 || start_i || expected_results.size() != 0)
               && waited < DRAIN_LIMIT);
    if (waited >= DRAIN_LIMIT) begin
      errors++;
      $display("%0d results never arrived", expected_results.size());
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (busy_o !== 1'b0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    @(posedge clk_i);
    case (idx)
      CFG_GRID_WIDTH:  width_reg = data[8:0];
      CFG_GRID_HEIGHT: height_reg = data[8:0];
      CFG_ANT_COUNT:   ants_reg = data[3:0];
      CFG_RULE_COUNT:  rules_reg = data[4:0];
      CFG_RULE_TURNS:  turns_reg = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned w, input int unsigned h,
                                input int unsigned n, input int unsigned rc,
                                input logic [31:0] turns);
    await_idle();
    @(posedge clk_i);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    write_reg(CFG_ANT_COUNT, n);
    write_reg(CFG_RULE_COUNT, rc);
    write_reg(CFG_RULE_TURNS, turns);
    cfg_valid_i <= 1'b0;
    settings_applied++;
    @(negedge clk_i);
  endtask

  // stimulus: reset, then one phase per register setting
  initial begin
    errors = 0;
    results_checked = 0;
    ticks_sent = 0;
    places_sent = 0;
    reads_sent = 0;
    rejects_seen = 0;
    settings_applied = 0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    ants_reg = 4'd1;
    rules_reg = 5'd2;
    turns_reg = 32'd13;
    foreach (grid_model[a]) grid_model[a] = '0;
    foreach (ant_x_now[a]) begin
      ant_x_now[a] = '0;
      ant_y_now[a] = '0;
      ant_dir_now[a] = HEAD_UP;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full grid, all ants, all rule states: corners and wrap at the edges
    apply_settings(256, 256, 8, 16, 32'h1B1B_E4E4);
    queue_request(OP_READ, 3'd0, 8'd0, 8'd0, HEAD_UP);
    queue_request(OP_READ, 3'd0, 8'd255, 8'd255, HEAD_UP);
    queue_request(OP_PLACE, 3'd1, 8'd255, 8'd0, HEAD_LEFT);
    queue_request(OP_PLACE, 3'd2, 8'd0, 8'd255, HEAD_DOWN);
    queue_request(OP_PLACE, 3'd3, 8'd128, 8'd128, HEAD_DOWN);
    queue_request(OP_PLACE, 3'd4, 8'd1, 8'd254, HEAD_LEFT);
    queue_request(OP_PLACE, 3'd5, 8'd254, 8'd1, HEAD_UP);
    queue_request(OP_PLACE, 3'd6, 8'd85, 8'd170, HEAD_RIGHT);
    queue_request(OP_PLACE, 3'd7, 8'd255, 8'd255, HEAD_LEFT);
    // revisit one cell so it climbs past the later rule count
    repeat (3) begin
      queue_request(OP_PLACE, 3'd0, 8'd1, 8'd1, HEAD_UP);
      queue_request(OP_TICK, 3'd7, 8'd255, 8'd255, HEAD_LEFT);
    end
    queue_request(OP_UNUSED, 3'd7, 8'd255, 8'd255, HEAD_LEFT);
    queue_request(OP_READ, 3'd0, 8'd1, 8'd1, HEAD_UP);
    queue_random(RANDOM_PER_PHASE);

    // small grid: ants left outside it, cells above the rule count, rejects
    apply_settings(4, 3, 3, 2, 32'd13);
    queue_request(OP_PLACE, 3'd0, 8'd1, 8'd1, HEAD_RIGHT);
    queue_request(OP_TICK, 3'd0, 8'd0, 8'd0, HEAD_UP);
    queue_request(OP_PLACE, 3'd2, 8'd4, 8'd0, HEAD_UP);
    queue_request(OP_PLACE, 3'd2, 8'd0, 8'd3, HEAD_UP);
    queue_request(OP_READ, 3'd0, 8'd255, 8'd0, HEAD_UP);
    queue_request(OP_READ, 3'd0, 8'd3, 8'd2, HEAD_UP);
    queue_random(RANDOM_PER_PHASE);

    // zero sizes and zero rule count act as one
    apply_settings(0, 0, 1, 0, $urandom);
    queue_random(RANDOM_PER_PHASE);

    // oversized values saturate
    apply_settings(300, 511, 12, 20, 32'hFFFF_FFFF);
    queue_random(RANDOM_PER_PHASE);

    // no ants: ticks give no result
    apply_settings(1, 256, 0, 1, 32'd0);
    queue_random(RANDOM_PER_PHASE);

    apply_settings(16, 16, 5, $urandom_range(1, 16), $urandom);
    queue_random(RANDOM_PER_PHASE);

    repeat (2) begin
      apply_settings($urandom_range(1, 256), $urandom_range(1, 256),
                     $urandom_range(1, 8), $urandom_range(1, 16), $urandom);
      queue_random(RANDOM_PER_PHASE);
    end

    // back to the power-on values
    apply_settings(256, 256, 1, 2, 32'd13);
    queue_random(RANDOM_PER_PHASE);

    await_idle();
    $display("run covered %0d ticks, %0d places, %0d reads, %0d rejected, %0d settings",
             ticks_sent, places_sent, reads_sent, rejects_seen, settings_applied);
    $display("%0d results checked, %0d errors", results_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog: covers the grid clear after reset and the slowest run many times over
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
